@@ hdl/ocle_pkg.sv @@
package ocle_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned POS_W  = 5;

   // command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_FIND   = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BADPOS   = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] read_value;
      logic [POS_W-1:0]  found_position;
      logic [POS_W-1:0]  entry_count;
   } rsp_type;

   // per-cell shift control
   typedef struct packed {
      logic ins;    // insert commits this cycle
      logic del;    // delete commits this cycle
      logic at;     // cell sits at the addressed position
      logic after;  // cell sits past the addressed position
   } cell_ctrl_type;

endpackage

@@ hdl/ocle_cell.sv @@
module ocle_cell (
   input  logic                           clock,
   input  ocle_pkg::cell_ctrl_type        ctrl,
   input  logic [ocle_pkg::DATA_W-1:0]    value,
   input  logic [ocle_pkg::DATA_W-1:0]    left_data,
   input  logic [ocle_pkg::DATA_W-1:0]    right_data,
   output logic [ocle_pkg::DATA_W-1:0]    data,
   output logic                           match
);
   import ocle_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (ctrl.at) begin
            data_in = value;
         end else if (ctrl.after) begin
            data_in = left_data;
         end
      end else if (ctrl.del && (ctrl.at || ctrl.after)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (data_ff == value);

endmodule

@@ hdl/ocle_find.sv @@
module ocle_find #(
   parameter int unsigned DEPTH = 16
) (
   input  logic [DEPTH-1:0]           hits,
   output logic                       any_hit,
   output logic [ocle_pkg::POS_W-1:0] position
);
   import ocle_pkg::*;

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DEPTH-1:0] lowest;
   logic [IDX_W-1:0] index;

   // isolate the lowest set bit, then encode the one-hot word
   assign lowest  = hits & (~hits + DEPTH'(1));
   assign any_hit = |hits;

   always_comb begin
      index = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if (lowest[k]) begin
            index = index | IDX_W'(k);
         end
      end
   end

   assign position = POS_W'({1'b0, index} + {{IDX_W{1'b0}}, 1'b1});

endmodule

@@ hdl/ordered_char_list_engine_top.sv @@
// Ordered byte list of up to DEPTH entries held in a row of shift cells.
// A command is taken at every clock edge where start is high (busy is
// always low); its single response appears on rsp_beat with rsp_strobe one
// cycle later and must be captured then, since it cannot be held off.
// Insert and delete shift every cell past the addressed position by one
// in that same cycle, and find compares all cells in parallel, so every
// command takes one cycle and the next one sees the updated list.
module ordered_char_list_engine_top #(
   parameter int unsigned DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ocle_pkg::req_type req_beat,
   output logic              rsp_strobe,
   output ocle_pkg::rsp_type rsp_beat
);
   import ocle_pkg::*;

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned EXT_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              strobe_ff;
   logic              strobe_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic              accept;
   logic [EXT_W-1:0]  pos_ext;
   logic [EXT_W-1:0]  pos_m1;
   logic [EXT_W-1:0]  cnt_ext;
   logic              pos_zero;
   logic              ins_bad;
   logic              full;
   logic              rd_bad;
   logic              do_ins;
   logic              do_del;
   logic [IDX_W-1:0]  rd_idx;

   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]  cell_match;
   logic [DEPTH-1:0]  hits;
   logic              any_hit;
   logic [POS_W-1:0]  hit_pos;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign pos_ext  = EXT_W'(req_beat.position);
   assign pos_m1   = pos_ext - EXT_W'(1);
   assign cnt_ext  = EXT_W'(count_ff);
   assign pos_zero = (req_beat.position == '0);
   assign ins_bad  = pos_zero || (pos_ext > cnt_ext + EXT_W'(1));
   assign full     = (cnt_ext == EXT_W'(DEPTH));
   assign rd_bad   = pos_zero || (pos_ext > cnt_ext);
   assign rd_idx   = pos_m1[IDX_W-1:0];

   assign do_ins = accept && (req_beat.cmd == CMD_INSERT) && !ins_bad && !full;
   assign do_del = accept && (req_beat.cmd == CMD_DELETE) && !rd_bad;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         cell_ctrl_type           ctrl;
         logic [DATA_W-1:0]       left_data;
         logic [DATA_W-1:0]       right_data;

         assign ctrl.ins   = do_ins;
         assign ctrl.del   = do_del;
         assign ctrl.at    = (EXT_W'(g) == pos_m1);
         assign ctrl.after = (EXT_W'(g) > pos_m1);

         if (g == 0) begin : g_first
            assign left_data = req_beat.value;
         end else begin : g_mid
            assign left_data = cell_data[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_data = '0;
         end else begin : g_inner
            assign right_data = cell_data[g+1];
         end

         ocle_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .value      (req_beat.value),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[g]),
            .match      (cell_match[g])
         );

         // only occupied cells take part in the search
         assign hits[g] = cell_match[g] && (EXT_W'(g) < cnt_ext);
      end
   endgenerate

   ocle_find #(
      .DEPTH (DEPTH)
   ) u_find (
      .hits     (hits),
      .any_hit  (any_hit),
      .position (hit_pos)
   );

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in                = '0;
      rsp_in.status         = ST_OK;
      case (req_beat.cmd)
         CMD_INSERT: begin
            if (ins_bad) begin
               rsp_in.status = ST_BADPOS;
            end else if (full) begin
               rsp_in.status = ST_FULL;
            end
         end
         CMD_DELETE: begin
            if (rd_bad) begin
               rsp_in.status = ST_BADPOS;
            end
         end
         CMD_FIND: begin
            if (any_hit) begin
               rsp_in.found_position = hit_pos;
            end else begin
               rsp_in.status = ST_NOTFOUND;
            end
         end
         CMD_READ: begin
            if (rd_bad) begin
               rsp_in.status = ST_BADPOS;
            end else begin
               rsp_in.read_value = cell_data[rd_idx];
            end
         end
         default: begin
            rsp_in.status = ST_BADPOS;
         end
      endcase
      rsp_in.entry_count = POS_W'(count_in);
   end

   assign strobe_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_beat   = rsp_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_one_beat_per_cmd : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted command gave no response beat");

   a_no_spurious_beat : assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response beat without a command");

   a_found_only_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_beat.found_position != '0) |-> rsp_beat.status == ST_OK)
      else $error("find position reported with error status");

   a_list_kept_on_error : assert property (@(posedge clock) disable iff (reset)
      (accept && !do_ins && !do_del) |=> $stable(count_ff))
      else $error("count moved on a non-updating command");

endmodule
